// ===== sv/cmcl_pkg.sv =====
// -----------------------------------------------------------------------------
// Collatz maximum cycle length package
// Shared constants, controller states and the command and status groups that
// pass between the controller and the datapath.
// -----------------------------------------------------------------------------
package cmcl_pkg;

    localparam int MEMO_DEPTH  = 65536;
    localparam int MEMO_AW     = $clog2(MEMO_DEPTH);
    localparam int BOUND_WIDTH = 20;
    localparam int VALUE_WIDTH = 64;
    localparam int LEN_WIDTH   = 10;

    localparam logic [LEN_WIDTH-1:0]   LEN_MAX   = '1;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
    localparam logic [VALUE_WIDTH-1:0] OVF_LIMIT =
        (VALUE_MAX - VALUE_WIDTH'(1)) / VALUE_WIDTH'(3);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_EVAL   = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_OUTPUT = 7'b1000000
    } t_state;

    typedef struct packed {
        logic in_open;
        logic clr_we;
        logic load_item;
        logic load_start;
        logic step;
        logic finish_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_end;
        logic range_last;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/collatz_max_cycle_length_core.sv =====
// -----------------------------------------------------------------------------
// Collatz maximum cycle length core
// Returns the largest 3n+1 cycle length over an inclusive range of values.
// -----------------------------------------------------------------------------
// The input channel carries two range bounds in either order; a transfer takes
// place when i_valid is high and o_stall is low. For each transfer the output
// channel delivers one result: both bounds unchanged, the largest cycle length
// in the range (saturating at 1023) and an overflow flag that is set when a
// trajectory would leave the 64-bit datapath.
// Values in the range are walked one after another by a single shared step
// unit. Each trajectory step passes through a read and an evaluate state, for
// the registered read of the memo store; each value also passes through a load
// and a done state, and a memo hit ends the walk early. After the last value
// the result is loaded into the output register once it is free, and the
// next item is then taken in the idle state.
// The block works on one item at a time: o_stall stays high from a transfer
// in until its result is loaded into the output register.
// After reset the memo store is cleared in a pass over all 65536 entries, one
// entry a cycle, during which o_stall is high. The output register holds a
// result while i_stall is high; a new item is still accepted then, and its
// result waits until the register is free.
// -----------------------------------------------------------------------------
module collatz_max_cycle_length_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_first_bound,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_second_bound,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [cmcl_pkg::BOUND_WIDTH-1:0]   o_echo_first,
    output logic [cmcl_pkg::BOUND_WIDTH-1:0]   o_echo_second,
    output logic [cmcl_pkg::LEN_WIDTH-1:0]     o_max_cycle_length,
    output logic                               o_overflow
);

    cmcl_pkg::t_cmd cmd;
    cmcl_pkg::t_sts sts;

    cmcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cmcl_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_first_bound      (i_first_bound),
        .i_second_bound     (i_second_bound),
        .i_out_stall        (i_stall),
        .o_out_valid        (o_valid),
        .o_echo_first       (o_echo_first),
        .o_echo_second      (o_echo_second),
        .o_max_cycle_length (o_max_cycle_length),
        .o_overflow         (o_overflow)
    );

    assign o_stall = !cmd.in_open;

endmodule

// ===== sv/cmcl_ctrl.sv =====
// -----------------------------------------------------------------------------
// Collatz maximum cycle length controller
// Sequences the memo clearing pass, the walk over the range and the result
// transfer.
// -----------------------------------------------------------------------------
module cmcl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  cmcl_pkg::t_sts  i_sts,
    output cmcl_pkg::t_cmd  o_cmd
);

    cmcl_pkg::t_state r_state;
    cmcl_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            cmcl_pkg::ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = cmcl_pkg::ST_IDLE;
                end
            end
            cmcl_pkg::ST_IDLE: begin
                o_cmd.in_open = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = cmcl_pkg::ST_LOAD;
                end
            end
            cmcl_pkg::ST_LOAD: begin
                o_cmd.load_start = 1'b1;
                n_state          = cmcl_pkg::ST_READ;
            end
            cmcl_pkg::ST_READ: begin
                n_state = cmcl_pkg::ST_EVAL;
            end
            cmcl_pkg::ST_EVAL: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.walk_end ? cmcl_pkg::ST_DONE : cmcl_pkg::ST_READ;
            end
            cmcl_pkg::ST_DONE: begin
                o_cmd.finish_start = 1'b1;
                n_state = i_sts.range_last ? cmcl_pkg::ST_OUTPUT : cmcl_pkg::ST_LOAD;
            end
            cmcl_pkg::ST_OUTPUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = cmcl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cmcl_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmcl_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/cmcl_dp.sv =====
// -----------------------------------------------------------------------------
// Collatz maximum cycle length datapath
// Holds the range, the trajectory value and count, the memo store of known
// cycle lengths and the output register.
// -----------------------------------------------------------------------------
module cmcl_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cmcl_pkg::t_cmd                        i_cmd,
    output cmcl_pkg::t_sts                        o_sts,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]      i_first_bound,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]      i_second_bound,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [cmcl_pkg::BOUND_WIDTH-1:0]      o_echo_first,
    output logic [cmcl_pkg::BOUND_WIDTH-1:0]      o_echo_second,
    output logic [cmcl_pkg::LEN_WIDTH-1:0]        o_max_cycle_length,
    output logic                                  o_overflow
);

    localparam int BW = cmcl_pkg::BOUND_WIDTH;
    localparam int VW = cmcl_pkg::VALUE_WIDTH;
    localparam int LW = cmcl_pkg::LEN_WIDTH;
    localparam int AW = cmcl_pkg::MEMO_AW;

    logic [LW-1:0] r_memo [cmcl_pkg::MEMO_DEPTH];
    logic [LW-1:0] r_rd_data;

    logic [BW-1:0] r_first;
    logic [BW-1:0] r_second;
    logic [BW-1:0] r_idx;
    logic [BW-1:0] r_end;
    logic [VW-1:0] r_traj;
    logic [LW-1:0] r_cnt;
    logic [LW-1:0] r_max;
    logic          r_ovf;
    logic          r_hit_ovf;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;
    logic [BW-1:0] r_out_first;
    logic [BW-1:0] r_out_second;
    logic [LW-1:0] r_out_max;
    logic          r_out_ovf;

    logic          traj_end;
    logic          traj_small;
    logic          memo_hit;
    logic          mul_ovf;
    logic [LW:0]   hit_sum;
    logic [LW:0]   inc_sum;
    logic [LW-1:0] hit_cnt;
    logic [LW-1:0] inc_cnt;
    logic [VW-1:0] triple;
    logic          idx_small;
    logic          memo_we;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    assign traj_end   = (r_traj <= VW'(1));
    assign traj_small = (r_traj < VW'(cmcl_pkg::MEMO_DEPTH));
    assign memo_hit   = traj_small && (r_rd_data != '0);
    assign mul_ovf    = r_traj[0] && (r_traj > cmcl_pkg::OVF_LIMIT);
    assign hit_sum    = {1'b0, r_cnt} + {1'b0, r_rd_data} - (LW+1)'(1);
    assign inc_sum    = {1'b0, r_cnt} + (LW+1)'(1);
    assign hit_cnt    = (hit_sum > {1'b0, cmcl_pkg::LEN_MAX}) ?
                        cmcl_pkg::LEN_MAX : hit_sum[LW-1:0];
    assign inc_cnt    = (inc_sum > {1'b0, cmcl_pkg::LEN_MAX}) ?
                        cmcl_pkg::LEN_MAX : inc_sum[LW-1:0];
    assign triple     = {r_traj[VW-2:0], 1'b0} + r_traj + VW'(1);
    assign idx_small  = (r_idx < BW'(cmcl_pkg::MEMO_DEPTH));

    assign memo_we = i_cmd.clr_we || (i_cmd.finish_start && !r_hit_ovf && idx_small);
    assign wr_addr = i_cmd.clr_we ? r_clr_addr : r_idx[AW-1:0];
    assign wr_data = i_cmd.clr_we ? '0 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (memo_we) begin
            r_memo[wr_addr] <= wr_data;
        end
        r_rd_data <= r_memo[r_traj[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_first  <= i_first_bound;
            r_second <= i_second_bound;
            r_idx    <= (i_first_bound < i_second_bound) ? i_first_bound : i_second_bound;
            r_end    <= (i_first_bound < i_second_bound) ? i_second_bound : i_first_bound;
            r_max    <= '0;
            r_ovf    <= 1'b0;
        end
        if (i_cmd.load_start) begin
            r_traj    <= VW'(r_idx);
            r_cnt     <= LW'(1);
            r_hit_ovf <= 1'b0;
        end
        if (i_cmd.step && !traj_end) begin
            if (memo_hit) begin
                r_cnt <= hit_cnt;
            end else if (mul_ovf) begin
                r_hit_ovf <= 1'b1;
            end else begin
                r_traj <= r_traj[0] ? triple : {1'b0, r_traj[VW-1:1]};
                r_cnt  <= inc_cnt;
            end
        end
        if (i_cmd.finish_start) begin
            if (r_cnt > r_max) begin
                r_max <= r_cnt;
            end
            r_ovf <= r_ovf | r_hit_ovf;
            if (r_idx != r_end) begin
                r_idx <= r_idx + BW'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out_first  <= r_first;
            r_out_second <= r_second;
            r_out_max    <= r_max;
            r_out_ovf    <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == AW'(cmcl_pkg::MEMO_DEPTH - 1));
    assign o_sts.walk_end   = traj_end || memo_hit || mul_ovf;
    assign o_sts.range_last = (r_idx == r_end);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_echo_first       = r_out_first;
    assign o_echo_second      = r_out_second;
    assign o_max_cycle_length = r_out_max;
    assign o_overflow         = r_out_ovf;

endmodule

// ===== sv/cmcl_chk.sv =====
// -----------------------------------------------------------------------------
// Collatz maximum cycle length port checker
// Watches the ports of the core for reset, handshake and result properties.
// -----------------------------------------------------------------------------
module cmcl_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_first_bound,
    input logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_second_bound,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [cmcl_pkg::BOUND_WIDTH-1:0]   o_echo_first,
    input logic [cmcl_pkg::BOUND_WIDTH-1:0]   o_echo_second,
    input logic [cmcl_pkg::LEN_WIDTH-1:0]     o_max_cycle_length,
    input logic                               o_overflow
);

    // Coming out of reset, no result is offered and the clearing pass holds off input.
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid && o_stall)
        else $error("result or input opening straight after reset");

    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input still open after a transfer in");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_echo_first)
            && $stable(o_echo_second) && $stable(o_max_cycle_length)
            && $stable(o_overflow))
        else $error("stalled result changed");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_max_cycle_length != '0)
        else $error("result with zero cycle length");

    a_input_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid || $past(o_valid && i_stall) || $stable(o_valid)
            || $rose(o_valid) == 1'b0)
        else $error("result appeared in the cycle after a transfer in");

endmodule

bind collatz_max_cycle_length_core cmcl_chk u_cmcl_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .i_first_bound      (i_first_bound),
    .i_second_bound     (i_second_bound),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_echo_first       (o_echo_first),
    .o_echo_second      (o_echo_second),
    .o_max_cycle_length (o_max_cycle_length),
    .o_overflow         (o_overflow)
);

// ===== dv/cmcl_range_checker.sv =====
// -----------------------------------------------------------------------------
// Collatz maximum cycle length checker
// Watches both channels of the core. Every transfer in is turned into the
// result it should cause by an independent walk of the 3n+1 rule over the
// range, with its own store of known lengths. Every transfer out is compared
// field by field with the oldest result still outstanding.
// -----------------------------------------------------------------------------
module cmcl_range_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_first_bound,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_second_bound,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_echo_first,
    input  logic [cmcl_pkg::BOUND_WIDTH-1:0]   i_echo_second,
    input  logic [cmcl_pkg::LEN_WIDTH-1:0]     i_max_cycle_length,
    input  logic                               i_overflow,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BW = cmcl_pkg::BOUND_WIDTH;
    localparam int VW = cmcl_pkg::VALUE_WIDTH;
    localparam int LW = cmcl_pkg::LEN_WIDTH;
    localparam int AW = cmcl_pkg::MEMO_AW;

    typedef struct packed {
        logic [BW-1:0] first_bound;
        logic [BW-1:0] second_bound;
        logic [LW-1:0] max_len;
        logic          overflow;
    } t_range_result;

    localparam int unsigned   LEN_CAP     = (1 << LW) - 1;
    localparam logic [VW-1:0] VALUE_TOP   = '1;
    localparam logic [VW-1:0] TRIPLE_EDGE = (VALUE_TOP - VW'(1)) / VW'(3);

    logic [LW-1:0] known_length [cmcl_pkg::MEMO_DEPTH];
    t_range_result outstanding_results [$];
    t_range_result want;
    t_range_result got;

    initial begin
        foreach (known_length[k]) known_length[k] = '0;
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int unsigned capped(input int unsigned n);
        return (n > LEN_CAP) ? LEN_CAP : n;
    endfunction

    // Length of one trajectory, including the final 1. A start value whose walk
    // leaves the datapath is not remembered.
    function automatic int unsigned walk_length(input logic [VW-1:0] start,
                                                inout logic ovf);
        logic [VW-1:0] v;
        int unsigned   steps;
        logic          left_datapath;
        left_datapath = 1'b0;
        if (start < VW'(cmcl_pkg::MEMO_DEPTH) && known_length[start[AW-1:0]] != '0)
            return 32'(known_length[start[AW-1:0]]);
        v     = start;
        steps = 1;
        while (v > VW'(1)) begin
            if (v < VW'(cmcl_pkg::MEMO_DEPTH) && known_length[v[AW-1:0]] != '0) begin
                steps = capped(steps + 32'(known_length[v[AW-1:0]]) - 1);
                break;
            end
            if (!v[0]) begin
                v = v >> 1;
            end else if (v > TRIPLE_EDGE) begin
                left_datapath = 1'b1;
                break;
            end else begin
                v = VW'(3) * v + VW'(1);
            end
            steps = capped(steps + 1);
        end
        if (left_datapath)
            ovf = 1'b1;
        else if (start < VW'(cmcl_pkg::MEMO_DEPTH))
            known_length[start[AW-1:0]] = steps[LW-1:0];
        return steps;
    endfunction

    function automatic t_range_result range_peak_length(input logic [BW-1:0] a,
                                                        input logic [BW-1:0] b);
        t_range_result r;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   n;
        int unsigned   peak;
        int unsigned   len;
        logic [VW-1:0] start;
        logic          ovf;
        lo   = (a < b) ? 32'(a) : 32'(b);
        hi   = (a < b) ? 32'(b) : 32'(a);
        peak = 0;
        ovf  = 1'b0;
        for (n = lo; n <= hi; n++) begin
            start = VW'(n);
            len   = walk_length(start, ovf);
            if (len > peak)
                peak = len;
        end
        r.first_bound  = a;
        r.second_bound = b;
        r.max_len      = peak[LW-1:0];
        r.overflow     = ovf;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                got.first_bound  = i_echo_first;
                got.second_bound = i_echo_second;
                got.max_len      = i_max_cycle_length;
                got.overflow     = i_overflow;
                if (outstanding_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d %0b",
                             $time, got.first_bound, got.second_bound, got.max_len,
                             got.overflow);
                    o_errors++;
                end else begin
                    want = outstanding_results.pop_front();
                    o_pending--;
                    check_field("echo_first", 32'(want.first_bound),
                                32'(got.first_bound));
                    check_field("echo_second", 32'(want.second_bound),
                                32'(got.second_bound));
                    check_field("max_cycle_length", 32'(want.max_len),
                                32'(got.max_len));
                    check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outstanding_results.push_back(range_peak_length(i_first_bound,
                                                                i_second_bound));
                o_pending++;
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// -----------------------------------------------------------------------------
// Collatz maximum cycle length testbench
// Drives range bounds into the core, first a directed set covering the bound
// extremes, a zero bound, reversed and equal bounds and the memo boundary,
// then random ranges of mostly small span with random gaps and stalls on both
// channels, including one long hold-off of the result channel. The checker
// beside the core predicts and compares every result.
// -----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BW = cmcl_pkg::BOUND_WIDTH;
    localparam int LW = cmcl_pkg::LEN_WIDTH;

    localparam int unsigned BOUND_TOP      = (1 << BW) - 1;
    localparam int unsigned MEMO_SIZE      = cmcl_pkg::MEMO_DEPTH;
    localparam int unsigned RANDOM_ITEMS   = 72;
    localparam int unsigned HOLD_CYCLES    = 2500;
    localparam int unsigned WATCHDOG_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES   = 200;

    logic          i_clk          = 1'b0;
    logic          i_rst_n        = 1'b0;
    logic          i_valid        = 1'b0;
    logic          i_stall        = 1'b0;
    logic [BW-1:0] i_first_bound  = '0;
    logic [BW-1:0] i_second_bound = '0;
    logic          o_stall;
    logic          o_valid;
    logic [BW-1:0] o_echo_first;
    logic [BW-1:0] o_echo_second;
    logic [LW-1:0] o_max_cycle_length;
    logic          o_overflow;

    int          errors;
    int          pending;
    int unsigned quiet_cycles = 0;
    logic        steady       = 1'b0;
    logic        hold_req     = 1'b0;
    logic        hold_on      = 1'b0;

    always #5 i_clk = ~i_clk;

    collatz_max_cycle_length_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_first_bound      (i_first_bound),
        .i_second_bound     (i_second_bound),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_echo_first       (o_echo_first),
        .o_echo_second      (o_echo_second),
        .o_max_cycle_length (o_max_cycle_length),
        .o_overflow         (o_overflow)
    );

    cmcl_range_checker u_range_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_first_bound      (i_first_bound),
        .i_second_bound     (i_second_bound),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_echo_first       (o_echo_first),
        .i_echo_second      (o_echo_second),
        .i_max_cycle_length (o_max_cycle_length),
        .i_overflow         (o_overflow),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 16);
        return $urandom_range(40, 150);
    endfunction

    task automatic send_range(input int unsigned a, input int unsigned b);
        int unsigned gap;
        i_valid        <= 1'b1;
        i_first_bound  <= BW'(a);
        i_second_bound <= BW'(b);
        do @(posedge i_clk); while (o_stall);
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side: random stall runs, none while steady, and one long hold-off
    // on request so that the core fills up and stalls its input.
    initial begin
        int unsigned pick;
        int unsigned run;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_on  = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
            end else if (steady) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    i_stall <= 1'b0;
                    run = $urandom_range(1, 8);
                end else if (pick < 85) begin
                    i_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end else if (pick < 97) begin
                    i_stall <= 1'b1;
                    run = $urandom_range(4, 16);
                end else begin
                    i_stall <= 1'b1;
                    run = $urandom_range(40, 150);
                end
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned k;
        int unsigned j;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_range(1, 1);
        send_range(0, 0);
        send_range(0, 1);
        send_range(5, 0);
        send_range(2, 2);
        send_range(BOUND_TOP, BOUND_TOP);
        send_range(BOUND_TOP, BOUND_TOP - 15);
        send_range(BOUND_TOP - 15, BOUND_TOP);
        send_range(1, 10);
        send_range(10, 1);
        send_range(27, 27);
        send_range(100, 200);
        send_range(210, 201);
        send_range(1000, 900);
        send_range(837799, 837799);
        send_range(MEMO_SIZE - 1, MEMO_SIZE);
        send_range(MEMO_SIZE + 1, MEMO_SIZE - 2);
        send_range(524288, 524287);
        send_range(0, 20);
        send_range(699050, 699051);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            steady = (k >= 40 && k < 65);
            if (k == 70) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                hold_req = 1'b1;
                wait (hold_on);
                steady = 1'b1;
                for (j = 0; j < 8; j++) begin
                    lo = $urandom_range(1, 8);
                    send_range(lo, lo);
                end
                steady = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                lo   = $urandom_range(0, BOUND_TOP);
                span = $urandom_range(0, 12);
            end else if (pick < 80) begin
                lo   = $urandom_range(0, 70000);
                span = $urandom_range(0, 24);
            end else if (pick < 96) begin
                lo   = $urandom_range(0, 4095);
                span = $urandom_range(0, 48);
            end else begin
                lo   = $urandom_range(0, 1023);
                span = $urandom_range(100, 400);
            end
            hi = (lo + span > BOUND_TOP) ? BOUND_TOP : lo + span;
            if ($urandom_range(0, 1))
                send_range(lo, hi);
            else
                send_range(hi, lo);
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
